>>> design/rgb3k_pkg.sv
package rgb3k_pkg;

    localparam int PIX_W = 24;
    localparam int H_MAX = 1024;

    localparam logic [1:0] MODE_EDGE    = 2'd0;
    localparam logic [1:0] MODE_SHARPEN = 2'd1;
    localparam logic [1:0] MODE_BOX     = 2'd2;
    localparam logic [1:0] MODE_GAUSS   = 2'd3;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_LEFT   = 3'd3;
    localparam logic [2:0] REG_TOP    = 3'd4;
    localparam logic [2:0] REG_RIGHT  = 3'd5;
    localparam logic [2:0] REG_BOTTOM = 3'd6;

    // floor(x / 9) == (x * BOX_RECIP) >> BOX_SHIFT for x up to 9 * 255
    localparam logic [11:0] BOX_RECIP = 12'd3641;
    localparam int          BOX_SHIFT = 15;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t top;
        pixel_t ctr;
        pixel_t bot;
    } column_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic       drain;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } out_word_t;

endpackage

>>> design/rgb3k_ram.sv
module rgb3k_ram
    #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
    )
    (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> design/rgb3k_cell.sv
module rgb3k_cell
    import rgb3k_pkg::*;
    (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    shift,
    input  column_t col_in,
    output column_t col_out
    );

    column_t col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
        end
        else if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> design/rgb3k_chan.sv
module rgb3k_chan
    import rgb3k_pkg::*;
    (
    input  logic [1:0]      mode,
    input  logic [8:0][7:0] taps,
    output logic [7:0]      result
    );

    logic [9:0]  edges;
    logic [9:0]  corners;
    logic [11:0] sum9;
    logic [13:0] s_signed;
    logic [23:0] box_prod;
    logic [11:0] gauss_sum;

    always_comb
    begin
        edges     = 10'(taps[1]) + 10'(taps[3]) + 10'(taps[5]) + 10'(taps[7]);
        corners   = 10'(taps[0]) + 10'(taps[2]) + 10'(taps[6]) + 10'(taps[8]);
        sum9      = 12'(corners) + 12'(edges) + 12'(taps[4]);
        box_prod  = 24'(sum9) * 24'(BOX_RECIP);
        gauss_sum = 12'(corners) + {1'b0, edges, 1'b0} + {2'b0, taps[4], 2'b0};
        s_signed  = '0;
        case (mode)
            MODE_EDGE:
            begin
                s_signed = ({3'b0, taps[4], 3'b0} + {6'b0, taps[4]}) - {2'b0, sum9};
            end
            MODE_SHARPEN:
            begin
                s_signed = ({4'b0, taps[4], 2'b0} + {6'b0, taps[4]}) - {4'b0, edges};
            end
            MODE_BOX:
            begin
                s_signed = 14'(box_prod >> BOX_SHIFT);
            end
            MODE_GAUSS:
            begin
                s_signed = 14'(gauss_sum >> 4);
            end
            default:
            begin
                s_signed = '0;
            end
        endcase
        if (s_signed[13])
        begin
            result = 8'd0;
        end
        else if (s_signed[12:8] != 5'd0)
        begin
            result = 8'd255;
        end
        else
        begin
            result = s_signed[7:0];
        end
    end

endmodule

>>> design/rgb_3x3_kernel_filter_core.sv
// 3x3 kernel filter for a raster rgb pixel stream.
// in channel: in_valid / in_stall / in_word, one pixel word per accepted edge;
//   drain words after the frame flush the row-plus-one-pixel lag.
// out channel: out_valid / out_stall / out_word, frame_last marks the final
//   pixel; its result also restarts the frame counters.
// cfg channel: cfg_valid / cfg_ready / cfg_index / cfg_data, always ready;
//   write only while the stream is idle.
// throughput: one word per cycle unless out_stall backs up the stages, set by
//   the single read and single write of the line store per cycle and the
//   three-column window shifting once per word.
// lag: a result's releasing word arrives image_width + 1 words after the pixel.
// reset: counters, window and valids clear, registers take their defaults;
//   line store contents are undefined and only feed border pixels.
// stall: the output register holds; the stages behind fill up and in_stall
//   rises once all three are occupied.
module rgb_3x3_kernel_filter_core
    import rgb3k_pkg::*;
    #(
    parameter int MAX_WIDTH = 1024
    )
    (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_word_t  in_word,
    output logic      out_valid,
    input  logic      out_stall,
    output out_word_t out_word,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
    );

    localparam int AW = $clog2(MAX_WIDTH);

    logic [1:0]  mode_reg;
    logic [10:0] iw_reg, ih_reg, sr_reg, sb_reg;
    logic [9:0]  sl_reg, st_reg;

    logic [10:0] col_reg;
    logic [11:0] row_reg;
    logic [21:0] emitted_reg;

    logic [10:0] w_eff, h_eff;
    logic [21:0] total;
    logic [23:0] pos;
    logic        complete, a_go, a_proc, a_emit, a_last, a_int, a_fwd;
    logic [11:0] pr;
    logic [10:0] pc;
    logic [AW-1:0] a_idx;
    pixel_t      a_pix;

    logic        b_valid_reg, b_emit_reg, b_int_reg, b_last_reg, b_fwd_reg;
    logic [AW-1:0] b_idx_reg;
    pixel_t      b_pix_reg, b_fup_reg, b_fmid_reg, b_up, b_mid;
    logic [47:0] ram_rdata;
    logic        b_fire;

    logic        c_valid_reg, c_int_reg, c_last_reg, c_free, c_fire;
    pixel_t      c_before_reg;
    logic        o_free;
    out_word_t   out_word_reg;
    logic        out_valid_reg;

    column_t     cols [3];
    column_t     new_col;
    logic [7:0]  filt [3];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EDGE;
            iw_reg   <= 11'd1024;
            ih_reg   <= 11'd1024;
            sl_reg   <= '0;
            st_reg   <= '0;
            sr_reg   <= 11'd1024;
            sb_reg   <= 11'd1024;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MODE:   mode_reg <= cfg_data[1:0];
                REG_WIDTH:  iw_reg   <= cfg_data;
                REG_HEIGHT: ih_reg   <= cfg_data;
                REG_LEFT:   sl_reg   <= cfg_data[9:0];
                REG_TOP:    st_reg   <= cfg_data[9:0];
                REG_RIGHT:  sr_reg   <= cfg_data;
                REG_BOTTOM: sb_reg   <= cfg_data;
                default:    ;
            endcase
        end
    end

    // position and border decisions
    always_comb
    begin
        if (iw_reg == 11'd0)
        begin
            w_eff = 11'd1;
        end
        else if (32'(iw_reg) > MAX_WIDTH)
        begin
            w_eff = 11'(MAX_WIDTH);
        end
        else
        begin
            w_eff = iw_reg;
        end
        if (ih_reg == 11'd0)
        begin
            h_eff = 11'd1;
        end
        else if (32'(ih_reg) > H_MAX)
        begin
            h_eff = 11'(H_MAX);
        end
        else
        begin
            h_eff = ih_reg;
        end
        total    = 22'(w_eff) * 22'(h_eff);
        pos      = 24'(row_reg) * 24'(w_eff) + 24'(col_reg);
        complete = pos >= 24'(total);
        a_go     = in_valid && !in_stall;
        a_proc   = a_go && !(in_word.drain && !complete);
        a_pix    = complete ? '0 : {in_word.in_red, in_word.in_green, in_word.in_blue};
        a_emit   = (row_reg >= 12'd2) || (row_reg == 12'd1 && col_reg != 11'd0);
        if (col_reg != 11'd0)
        begin
            pr = row_reg - 12'd1;
            pc = col_reg - 11'd1;
        end
        else
        begin
            pr = row_reg - 12'd2;
            pc = w_eff - 11'd1;
        end
        a_int = (pr >= 12'd1) && (13'(pr) + 13'd2 <= 13'(h_eff))
             && (pc >= 11'd1) && (12'(pc) + 12'd2 <= 12'(w_eff))
             && (pc >= 11'(sl_reg)) && (pc < sr_reg)
             && (pr >= 12'(st_reg)) && (pr < 12'(sb_reg));
        a_last = (23'(emitted_reg) + 23'd1) >= 23'(total);
        a_idx  = (32'(col_reg) >= MAX_WIDTH) ? AW'(MAX_WIDTH - 1) : AW'(col_reg);
        a_fwd  = b_fire && (b_idx_reg == a_idx);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            emitted_reg <= '0;
        end
        else if (a_proc)
        begin
            if (a_emit && a_last)
            begin
                col_reg     <= '0;
                row_reg     <= '0;
                emitted_reg <= '0;
            end
            else
            begin
                if (12'(col_reg) + 12'd1 >= 12'(w_eff))
                begin
                    col_reg <= '0;
                    row_reg <= row_reg + 12'd1;
                end
                else
                begin
                    col_reg <= col_reg + 11'd1;
                end
                if (a_emit)
                begin
                    emitted_reg <= emitted_reg + 22'd1;
                end
            end
        end
    end

    // upper and middle rows share one address, so they share one memory
    rgb3k_ram
        #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
        )
    u_rows
        (
        .clk   (clk),
        .we    (b_fire),
        .waddr (b_idx_reg),
        .wdata ({b_mid, b_pix_reg}),
        .re    (a_proc),
        .raddr (a_idx),
        .rdata (ram_rdata)
        );

    assign b_up   = b_fwd_reg ? b_fup_reg  : ram_rdata[2*PIX_W-1:PIX_W];
    assign b_mid  = b_fwd_reg ? b_fmid_reg : ram_rdata[PIX_W-1:0];

    assign o_free   = !out_valid_reg || !out_stall;
    assign c_fire   = c_valid_reg && o_free;
    assign c_free   = !c_valid_reg || c_fire;
    assign b_fire   = b_valid_reg && c_free;
    assign in_stall = b_valid_reg && !b_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (a_go)
        begin
            b_valid_reg <= a_proc;
        end
        else if (b_fire)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_proc)
        begin
            b_idx_reg  <= a_idx;
            b_pix_reg  <= a_pix;
            b_emit_reg <= a_emit;
            b_int_reg  <= a_int;
            b_last_reg <= a_last;
            b_fwd_reg  <= a_fwd;
            b_fup_reg  <= b_mid;
            b_fmid_reg <= b_pix_reg;
        end
    end

    assign new_col = '{top: b_up, ctr: b_mid, bot: b_pix_reg};

    rgb3k_cell u_cell2 (.clk(clk), .rst_n(rst_n), .shift(b_fire),
                        .col_in(new_col), .col_out(cols[2]));
    rgb3k_cell u_cell1 (.clk(clk), .rst_n(rst_n), .shift(b_fire),
                        .col_in(cols[2]), .col_out(cols[1]));
    rgb3k_cell u_cell0 (.clk(clk), .rst_n(rst_n), .shift(b_fire),
                        .col_in(cols[1]), .col_out(cols[0]));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (c_free)
        begin
            c_valid_reg <= b_fire && b_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_fire)
        begin
            c_int_reg    <= b_int_reg;
            c_last_reg   <= b_last_reg;
            c_before_reg <= cols[2].ctr;
        end
    end

    genvar ch;
    generate
        for (ch = 0; ch < 3; ch++)
        begin : g_chan
            localparam int LSB = 16 - 8 * ch;
            logic [8:0][7:0] taps;
            always_comb
            begin
                taps[0] = cols[0].top[LSB+7:LSB];
                taps[1] = cols[1].top[LSB+7:LSB];
                taps[2] = cols[2].top[LSB+7:LSB];
                taps[3] = cols[0].ctr[LSB+7:LSB];
                taps[4] = cols[1].ctr[LSB+7:LSB];
                taps[5] = cols[2].ctr[LSB+7:LSB];
                taps[6] = cols[0].bot[LSB+7:LSB];
                taps[7] = cols[1].bot[LSB+7:LSB];
                taps[8] = cols[2].bot[LSB+7:LSB];
            end
            rgb3k_chan u_chan (.mode(mode_reg), .taps(taps), .result(filt[ch]));
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (o_free)
        begin
            out_valid_reg <= c_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_fire)
        begin
            if (c_int_reg)
            begin
                out_word_reg.out_red   <= filt[0];
                out_word_reg.out_green <= filt[1];
                out_word_reg.out_blue  <= filt[2];
            end
            else
            begin
                out_word_reg.out_red   <= c_before_reg[23:16];
                out_word_reg.out_green <= c_before_reg[15:8];
                out_word_reg.out_blue  <= c_before_reg[7:0];
            end
            out_word_reg.frame_last <= c_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (b_valid_reg && c_valid_reg && out_valid_reg))
        else $error("input stalled with a free stage");

    a_fwd_from_live: assert property (@(posedge clk) disable iff (!rst_n)
        (a_proc && a_fwd) |-> b_valid_reg)
        else $error("forward taken from an empty stage");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (a_proc && a_emit && a_last) |=> (col_reg == '0 && row_reg == '0))
        else $error("frame counters not restarted after last pixel");

endmodule

>>> sim/rgb3k_checker.sv
`timescale 1ns / 100ps

module rgb3k_checker
    import rgb3k_pkg::*;
    (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  in_word_t    in_word,
    input  logic        out_valid,
    input  logic        out_stall,
    input  out_word_t   out_word,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data,
    output int          fail_count,
    output int          pending
    );

    localparam int STORE_DEPTH = 1024;

    logic [1:0]  mode_q;
    logic [10:0] width_q, height_q, right_q, bottom_q;
    logic [9:0]  left_q, top_q;

    pixel_t upper_row [STORE_DEPTH];
    pixel_t middle_row [STORE_DEPTH];
    pixel_t win [3][3];
    int unsigned col_pos, row_pos, sent_in_frame;

    out_word_t filtered_q[$];

    function automatic int tap(input logic [1:0] m, input int k);
        case (m)
            MODE_EDGE:    return (k == 4) ? 8 : -1;
            MODE_SHARPEN: return (k == 4) ? 5 : ((k % 2) == 1 ? -1 : 0);
            MODE_BOX:     return 1;
            default:      return (k == 4) ? 4 : ((k % 2) == 1 ? 2 : 1);
        endcase
    endfunction

    function automatic logic [7:0] filter_chan(input int sh);
        int sum;
        int v;
        sum = 0;
        for (int k = 0; k < 9; k++)
        begin
            v = (win[k / 3][k % 3] >> sh) & 255;
            sum += tap(mode_q, k) * v;
        end
        if (sum < 0)
            return 8'd0;
        if (mode_q == MODE_BOX)
            sum = sum / 9;
        else if (mode_q == MODE_GAUSS)
            sum = sum / 16;
        return (sum > 255) ? 8'd255 : sum[7:0];
    endfunction

    function automatic int unsigned eff_dim(input logic [10:0] v);
        if (v == 0)
            return 1;
        return (v > STORE_DEPTH) ? STORE_DEPTH : v;
    endfunction

    task automatic predict_pixel(input in_word_t w);
        int unsigned wd, ht, total, col, row, idx, pr, pc;
        pixel_t pix, prev, up, mid, val;
        logic complete, emit, interior, last;
        out_word_t res;
        wd = eff_dim(width_q);
        ht = eff_dim(height_q);
        total = wd * ht;
        col = col_pos;
        row = row_pos;
        complete = (row * wd + col) >= total;
        if (w.drain && !complete)
            return;
        pix = complete ? '0 : {w.in_red, w.in_green, w.in_blue};
        prev = win[1][2];
        idx = (col < STORE_DEPTH) ? col : STORE_DEPTH - 1;
        up = upper_row[idx];
        mid = middle_row[idx];
        upper_row[idx] = mid;
        middle_row[idx] = pix;
        for (int i = 0; i < 3; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = up;
        win[1][2] = mid;
        win[2][2] = pix;
        emit = (row >= 2) || (row == 1 && col >= 1);
        pr = 0;
        pc = 0;
        val = '0;
        if (emit)
        begin
            if (col >= 1)
            begin
                pr = row - 1;
                pc = col - 1;
                val = win[1][1];
            end
            else
            begin
                pr = row - 2;
                pc = wd - 1;
                val = prev;
            end
        end
        if (col + 1 >= wd)
        begin
            col_pos = 0;
            row_pos = row + 1;
        end
        else
            col_pos = col + 1;
        if (!emit)
            return;
        interior = pr >= 1 && pr + 2 <= ht && pc >= 1 && pc + 2 <= wd
            && pc >= left_q && pc < right_q && pr >= top_q && pr < bottom_q;
        if (interior)
            val = {filter_chan(16), filter_chan(8), filter_chan(0)};
        last = (sent_in_frame + 1) >= total;
        res.out_red = val[23:16];
        res.out_green = val[15:8];
        res.out_blue = val[7:0];
        res.frame_last = last;
        filtered_q.push_back(res);
        sent_in_frame++;
        if (last)
        begin
            col_pos = 0;
            row_pos = 0;
            sent_in_frame = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t exp_w;
        if (!rst_n)
        begin
            mode_q = MODE_EDGE;
            width_q = 11'd1024;
            height_q = 11'd1024;
            left_q = '0;
            top_q = '0;
            right_q = 11'd1024;
            bottom_q = 11'd1024;
            for (int i = 0; i < STORE_DEPTH; i++)
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            for (int i = 0; i < 9; i++)
                win[i / 3][i % 3] = '0;
            col_pos = 0;
            row_pos = 0;
            sent_in_frame = 0;
            filtered_q.delete();
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (filtered_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected output word %h", out_word);
                end
                else
                begin
                    exp_w = filtered_q.pop_front();
                    if (exp_w !== out_word)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: exp r%h g%h b%h l%b got r%h g%h b%h l%b",
                                exp_w.out_red, exp_w.out_green, exp_w.out_blue,
                                exp_w.frame_last, out_word.out_red, out_word.out_green,
                                out_word.out_blue, out_word.frame_last);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_MODE:   mode_q = cfg_data[1:0];
                    REG_WIDTH:  width_q = cfg_data;
                    REG_HEIGHT: height_q = cfg_data;
                    REG_LEFT:   left_q = cfg_data[9:0];
                    REG_TOP:    top_q = cfg_data[9:0];
                    REG_RIGHT:  right_q = cfg_data;
                    REG_BOTTOM: bottom_q = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                predict_pixel(in_word);
            pending = filtered_q.size();
        end
    end

endmodule

>>> sim/tb_rgb_3x3_kernel_filter_core.sv
`timescale 1ns / 100ps

module tb_rgb_3x3_kernel_filter_core;
    import rgb3k_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;
    int          fail_count;
    int          pending;

    int burst_left;
    int word_count;
    int stall_mode;
    int stall_span;
    int stall_phase;

    rgb_3x3_kernel_filter_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    rgb3k_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_word    (in_word),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_word   (out_word),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver stall pattern
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_mode <= 0;
            stall_span <= 0;
            stall_phase <= 0;
        end
        else
        begin
            if (stall_span == 0)
            begin
                stall_mode <= $urandom_range(0, 3);
                stall_span <= $urandom_range(20, 300);
            end
            else
                stall_span <= stall_span - 1;
            stall_phase <= stall_phase + 1;
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 9) < 3);
                2: out_stall <= (stall_phase % 3) == 0;
                default: out_stall <= ($urandom_range(0, 9) < 8);
            endcase
        end
    end

    task automatic send_word(input in_word_t w);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        word_count++;
    endtask

    task automatic send_pixel(input logic is_drain, input int extreme);
        in_word_t w;
        w.in_red = 8'($urandom);
        w.in_green = 8'($urandom);
        w.in_blue = 8'($urandom);
        if (extreme == 1)
        begin
            w.in_red = '1;
            w.in_green = '1;
            w.in_blue = '1;
        end
        else if (extreme == 2)
        begin
            w.in_red = '0;
            w.in_green = '0;
            w.in_blue = '0;
        end
        w.drain = is_drain;
        send_word(w);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [10:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_frame(input logic [1:0] m, input int w, input int h, input int l,
                             input int t, input int r, input int b);
        wait_idle();
        write_reg(REG_MODE, 11'(m));
        write_reg(REG_WIDTH, 11'(w));
        write_reg(REG_HEIGHT, 11'(h));
        write_reg(REG_LEFT, 11'(l));
        write_reg(REG_TOP, 11'(t));
        write_reg(REG_RIGHT, 11'(r));
        write_reg(REG_BOTTOM, 11'(b));
        @(posedge clk);
    endtask

    // full frame then one row plus one word of flush
    task automatic run_frame(input int w, input int h, input int extreme_pct,
                             input int pause_at);
        int wd;
        int ht;
        int x;
        wd = (w == 0) ? 1 : ((w > 1024) ? 1024 : w);
        ht = (h == 0) ? 1 : ((h > 1024) ? 1024 : h);
        for (int p = 0; p < wd * ht; p++)
        begin
            if ($urandom_range(0, 11) == 0)
                send_pixel(1'b1, 0);
            if (p == pause_at)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            x = ($urandom_range(0, 99) < extreme_pct) ? $urandom_range(1, 2) : 0;
            send_pixel(1'b0, x);
        end
        for (int p = 0; p <= wd; p++)
            send_pixel($urandom_range(0, 3) != 0, 0);
    endtask

    initial
    begin
        int w;
        int h;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        burst_left = 0;
        word_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_frame(MODE_EDGE, 4, 4, 0, 0, 1024, 1024);
        run_frame(4, 4, 60, 7);
        set_frame(MODE_SHARPEN, 3, 3, 0, 0, 2047, 2047);
        run_frame(3, 3, 60, -1);
        set_frame(MODE_BOX, 5, 3, 1, 1, 4, 2);
        run_frame(5, 3, 60, -1);
        set_frame(MODE_GAUSS, 4, 5, 1023, 1023, 0, 0);
        run_frame(4, 5, 60, -1);
        set_frame(MODE_EDGE, 0, 0, 0, 0, 1, 1);
        run_frame(0, 0, 0, -1);

        while (word_count < 1100)
        begin
            w = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 10);
            h = $urandom_range(1, 7);
            set_frame(2'($urandom_range(0, 3)), w, h,
                $urandom_range(0, w), $urandom_range(0, h),
                $urandom_range(0, w + 1), $urandom_range(0, h + 1));
            repeat ($urandom_range(1, 3))
                run_frame(w, h, 15, -1);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> rgb_3x3_kernel_filter_core.f
design/rgb3k_pkg.sv
design/rgb3k_ram.sv
design/rgb3k_cell.sv
design/rgb3k_chan.sv
design/rgb_3x3_kernel_filter_core.sv
sim/rgb3k_checker.sv
sim/tb_rgb_3x3_kernel_filter_core.sv
